// ===== rtl/smx_pkg.sv =====
// Package for the stack machine execute unit: opcodes, fault codes,
// sequencer states, ALU control struct and default sizes.
// No dependencies.
`default_nettype none

package smx_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int CODE_DEPTH_DEF  = 32;
    localparam int Q_W             = 32;
    localparam int OP_W            = 4;
    localparam int TGT_W           = 5;
    localparam int NPC_W           = 5;
    localparam int FAULT_W         = 2;
    localparam int S_TDATA_W       = 48;
    localparam int M_TDATA_W       = 40;
    localparam int M_TUSER_W       = 4;

    typedef enum logic [OP_W-1:0] {
        OP_HALT    = 4'd0,
        OP_PUSH    = 4'd1,
        OP_PUSHACC = 4'd2,
        OP_POPACC  = 4'd3,
        OP_ADD     = 4'd4,
        OP_SUB     = 4'd5,
        OP_MUL     = 4'd6,
        OP_OUT     = 4'd7,
        OP_JMP     = 4'd8,
        OP_JBE     = 4'd9
    } op_t;

    typedef enum logic [FAULT_W-1:0] {
        FAULT_NONE      = 2'd0,
        FAULT_UNDERFLOW = 2'd1,
        FAULT_OVERFLOW  = 2'd2,
        FAULT_UNKNOWN   = 2'd3
    } fault_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MUL
    } state_t;

    typedef struct packed {
        logic sub;
        logic mul_load;
    } alu_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/stack_machine_execute_unit.sv =====
// Stack machine execute unit top level: sequencer, stack pointer, pc,
// accumulator and result register around the stack RAM and the ALU.
// Depends on smx_pkg, smx_ram, smx_alu.
// An input transfer starts the registered read of the stack RAM; the
// result is formed in ST_EXEC (multiply adds ST_MUL and the registered
// product of the multiplier) and waits there while the previous output is
// stalled. One instruction at a time: no new input until the result is registered.
// Reset: stack count, accumulator and pc clear at once; stack RAM contents
// are not cleared and need no clearing pass.
`default_nettype none

module stack_machine_execute_unit
    import smx_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int CODE_DEPTH  = CODE_DEPTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // opcode[3:0], imm_value[35:4], jump_target[40:36], zero pad
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // next_pc[4:0], out_value[36:5], zero pad
    output logic      [M_TDATA_W-1:0] m_tdata,
    // out_valid[0], halted[1], fault[3:2]
    output logic      [M_TUSER_W-1:0] m_tuser
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int PW = $clog2(CODE_DEPTH);
    localparam logic [16:0] CD17 = 17'(CODE_DEPTH);

    state_t               state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [Q_W-1:0]       acc_reg, acc_next;
    logic [PW-1:0]        pc_reg, pc_next;

    logic [OP_W-1:0]      op_reg;
    logic [Q_W-1:0]       imm_reg;
    logic [TGT_W-1:0]     tgt_reg;

    logic                 m_tvalid_reg;
    logic [NPC_W-1:0]     npc_reg;
    logic                 ovalid_reg;
    logic [Q_W-1:0]       oval_reg;
    logic                 halt_reg;
    fault_t               fault_reg;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [Q_W-1:0]       ram_wdata;
    logic                 ram_re;
    logic [AW-1:0]        addr_top;
    logic [AW-1:0]        addr_sec;
    logic [Q_W-1:0]       top_val;
    logic [Q_W-1:0]       sec_val;
    logic [CW-1:0]        cnt_m1;
    logic [CW-1:0]        cnt_m2;

    alu_ctl_t             alu_ctl;
    logic signed [Q_W-1:0] addsub_res;
    logic signed [Q_W-1:0] mul_res;

    logic [PW-1:0]        pc_inc1;
    logic [PW-1:0]        pc_inc2;
    logic [PW-1:0]        tgt_pc;
    logic [PW:0]          s1;
    logic [PW:0]          s2;
    logic [4:0]           tmod;
    logic [PW+4:0]        tgt_wide;
    logic [PW+4:0]        res_pc_wide;

    logic                 has1;
    logic                 has2;
    logic                 full;
    logic                 finish;
    logic                 out_free;
    logic                 done;
    logic [PW-1:0]        res_pc;
    logic                 res_ovalid;
    logic [Q_W-1:0]       res_oval;
    logic                 res_halt;
    fault_t               res_fault;

    assign cnt_m1   = count_reg - CW'(1);
    assign cnt_m2   = count_reg - CW'(2);
    assign addr_top = cnt_m1[AW-1:0];
    assign addr_sec = cnt_m2[AW-1:0];
    assign has1     = (count_reg != '0);
    assign has2     = (count_reg >= CW'(2));
    assign full     = (count_reg >= CW'(STACK_DEPTH));
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;

    smx_ram #(
        .WIDTH (Q_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .re      (ram_re),
        .raddr_a (addr_top),
        .raddr_b (addr_sec),
        .rdata_a (top_val),
        .rdata_b (sec_val)
    );

    smx_alu u_alu (
        .clk        (clk),
        .ctl        (alu_ctl),
        .sec        (sec_val),
        .top        (top_val),
        .addsub_res (addsub_res),
        .mul_res    (mul_res)
    );

    always_comb
    begin
        s1 = {1'b0, pc_reg} + (PW+1)'(1);
        s2 = {1'b0, pc_reg} + (PW+1)'(2);
        if (s1 >= (PW+1)'(CODE_DEPTH))
        begin
            s1 = s1 - (PW+1)'(CODE_DEPTH);
        end
        if (s2 >= (PW+1)'(CODE_DEPTH))
        begin
            s2 = s2 - (PW+1)'(CODE_DEPTH);
        end
        pc_inc1 = s1[PW-1:0];
        pc_inc2 = s2[PW-1:0];
        tmod = tgt_reg;
        for (int i = 0; i < 8; i++)
        begin
            if ({12'b0, tmod} >= CD17)
            begin
                tmod = tmod - CD17[4:0];
            end
        end
        tgt_wide = (PW+5)'(tmod);
        tgt_pc   = tgt_wide[PW-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        acc_next   = acc_reg;
        pc_next    = pc_reg;
        ram_we     = 1'b0;
        ram_waddr  = count_reg[AW-1:0];
        ram_wdata  = imm_reg;
        ram_re     = 1'b0;
        alu_ctl    = '0;
        finish     = 1'b0;
        done       = 1'b0;
        res_ovalid = 1'b0;
        res_oval   = '0;
        res_halt   = 1'b0;
        res_fault  = FAULT_NONE;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    ram_re     = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                finish = 1'b1;
                unique case (op_t'(op_reg)) inside
                    OP_HALT:
                    begin
                        res_halt = 1'b1;
                    end
                    OP_PUSH, OP_PUSHACC:
                    begin
                        if (full)
                        begin
                            res_fault = FAULT_OVERFLOW;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            ram_wdata  = (op_t'(op_reg) == OP_PUSH) ? imm_reg : acc_reg;
                            count_next = count_reg + CW'(1);
                            pc_next    = (op_t'(op_reg) == OP_PUSH) ? pc_inc2 : pc_inc1;
                        end
                    end
                    OP_POPACC:
                    begin
                        if (!has1)
                        begin
                            res_fault = FAULT_UNDERFLOW;
                        end
                        else
                        begin
                            acc_next   = top_val;
                            count_next = cnt_m1;
                            pc_next    = pc_inc1;
                        end
                    end
                    OP_ADD, OP_SUB:
                    begin
                        if (!has2)
                        begin
                            res_fault = FAULT_UNDERFLOW;
                        end
                        else
                        begin
                            alu_ctl.sub = (op_t'(op_reg) == OP_SUB);
                            ram_we      = 1'b1;
                            ram_waddr   = addr_sec;
                            ram_wdata   = addsub_res;
                            count_next  = cnt_m1;
                            pc_next     = pc_inc1;
                        end
                    end
                    OP_MUL:
                    begin
                        if (!has2)
                        begin
                            res_fault = FAULT_UNDERFLOW;
                        end
                        else
                        begin
                            alu_ctl.mul_load = 1'b1;
                            finish           = 1'b0;
                            state_next       = ST_MUL;
                        end
                    end
                    OP_OUT:
                    begin
                        if (!has1)
                        begin
                            res_fault = FAULT_UNDERFLOW;
                        end
                        else
                        begin
                            res_ovalid = 1'b1;
                            res_oval   = top_val;
                            pc_next    = pc_inc1;
                        end
                    end
                    OP_JMP:
                    begin
                        pc_next = tgt_pc;
                    end
                    OP_JBE:
                    begin
                        if (!has2)
                        begin
                            res_fault = FAULT_UNDERFLOW;
                        end
                        else if ($signed(sec_val) <= $signed(top_val))
                        begin
                            pc_next = tgt_pc;
                        end
                        else
                        begin
                            pc_next = pc_inc2;
                        end
                    end
                    default:
                    begin
                        res_fault = FAULT_UNKNOWN;
                    end
                endcase
            end
            ST_MUL:
            begin
                finish     = 1'b1;
                ram_we     = 1'b1;
                ram_waddr  = addr_sec;
                ram_wdata  = mul_res;
                count_next = cnt_m1;
                pc_next    = pc_inc1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        res_pc = pc_next;
        if (finish && !out_free)
        begin
            state_next = state_reg;
            count_next = count_reg;
            acc_next   = acc_reg;
            pc_next    = pc_reg;
            ram_we     = 1'b0;
        end
        else if (finish)
        begin
            done       = 1'b1;
            state_next = ST_IDLE;
        end
    end

    assign res_pc_wide = (PW+5)'(res_pc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            acc_reg      <= '0;
            pc_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            acc_reg   <= acc_next;
            pc_reg    <= pc_next;
            if (done)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            op_reg  <= s_tdata[3:0];
            imm_reg <= s_tdata[35:4];
            tgt_reg <= s_tdata[40:36];
        end
        if (done)
        begin
            npc_reg    <= res_pc_wide[NPC_W-1:0];
            ovalid_reg <= res_ovalid;
            oval_reg   <= res_oval;
            halt_reg   <= res_halt;
            fault_reg  <= res_fault;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, oval_reg, npc_reg};
    assign m_tuser  = {fault_reg, halt_reg, ovalid_reg};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_EXEC))
        else $error("transfer not followed by execute");

    a_fault_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (done && res_fault != FAULT_NONE) |=>
        ($stable(count_reg) && $stable(pc_reg) && $stable(acc_reg)))
        else $error("faulting instruction changed state");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 (count_reg == $past(count_reg) || count_reg == $past(count_reg) + CW'(1)
            || count_reg == $past(count_reg) - CW'(1)))
        else $error("stack count jumped");

    a_we_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (done && state_reg != ST_IDLE))
        else $error("stack write outside instruction completion");

endmodule

`default_nettype wire

// ===== rtl/smx_ram.sv =====
// Generic synchronous RAM: one write port, two read ports, registered read.
// No dependencies.
`default_nettype none

module smx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/smx_alu.sv =====
// Saturating Q16.16 arithmetic: combinational add/sub, multiply with a
// registered product and rounding plus saturation in the next cycle.
// Depends on smx_pkg.
`default_nettype none

module smx_alu
    import smx_pkg::*;
(
    input  wire logic                  clk,
    input  wire alu_ctl_t              ctl,
    input  wire logic signed [Q_W-1:0] sec,
    input  wire logic signed [Q_W-1:0] top,
    output logic signed      [Q_W-1:0] addsub_res,
    output logic signed      [Q_W-1:0] mul_res
);

    logic signed [2*Q_W-1:0] prod_reg;
    logic signed [Q_W:0]     sum;
    logic signed [2*Q_W-1:0] rounded;
    logic signed [2*Q_W-1:0] shifted;

    always_ff @(posedge clk)
    begin
        if (ctl.mul_load)
        begin
            prod_reg <= sec * top;
        end
    end

    always_comb
    begin
        if (ctl.sub)
        begin
            sum = {sec[Q_W-1], sec} - {top[Q_W-1], top};
        end
        else
        begin
            sum = {sec[Q_W-1], sec} + {top[Q_W-1], top};
        end
        if (sum[Q_W] != sum[Q_W-1])
        begin
            addsub_res = sum[Q_W] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
        end
        else
        begin
            addsub_res = sum[Q_W-1:0];
        end
    end

    always_comb
    begin
        rounded = prod_reg + 64'sd32768;
        shifted = rounded >>> 16;
        if (shifted > 64'sd2147483647)
        begin
            mul_res = {1'b0, {(Q_W-1){1'b1}}};
        end
        else if (shifted < -64'sd2147483648)
        begin
            mul_res = {1'b1, {(Q_W-1){1'b0}}};
        end
        else
        begin
            mul_res = shifted[Q_W-1:0];
        end
    end

endmodule

`default_nettype wire
